FILE: rtl/infix_to_postfix_converter_unit_macros.svh
// Assertion helpers for the infix to postfix converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ITP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/itp_pkg.sv
package itp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CH_OPEN  = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE = 8'h29;  // )
  localparam logic [7:0] CH_MUL   = 8'h2A;  // *
  localparam logic [7:0] CH_ADD   = 8'h2B;  // +
  localparam logic [7:0] CH_SUB   = 8'h2D;  // -
  localparam logic [7:0] CH_DIV   = 8'h2F;  // /
  localparam logic [7:0] CH_POW   = 8'h5E;  // ^
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5,
    OP_NONE = 3'd7
  } op_code_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_CLOSE = 2'd2,
    ERR_OPEN  = 2'd3
  } err_e;

  // Source of the emitted character.
  typedef enum logic [1:0] {
    SEL_SYM,
    SEL_TOP,
    SEL_SPACE,
    SEL_ZERO
  } sel_e;

  typedef struct packed {
    logic load;
    logic emit;
    sel_e sel;
    logic last;
    logic done;
    err_e err;
    logic push;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic     eoe;
    logic     is_close;
    op_code_e cls;
    logic     empty;
    logic     full;
    logic     top_open;
    logic     top_ge;
    logic     out_free;
  } stat_t;

  function automatic op_code_e classify(input logic [7:0] sym);
    op_code_e c;
    case (sym)
      CH_OPEN: c = OP_OPEN;
      CH_ADD:  c = OP_ADD;
      CH_SUB:  c = OP_SUB;
      CH_MUL:  c = OP_MUL;
      CH_DIV:  c = OP_DIV;
      CH_POW:  c = OP_POW;
      default: c = OP_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] code_char(input op_code_e c);
    logic [7:0] ch;
    case (c)
      OP_OPEN: ch = CH_OPEN;
      OP_ADD:  ch = CH_ADD;
      OP_SUB:  ch = CH_SUB;
      OP_MUL:  ch = CH_MUL;
      OP_DIV:  ch = CH_DIV;
      OP_POW:  ch = CH_POW;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(input op_code_e c);
    logic [1:0] p;
    case (c)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/itp_if.sv
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expression;

  modport source (output valid, output symbol, output end_of_expression, input ready);
  modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

interface itp_out_if;
  logic         valid;
  logic         ready;
  logic [7:0]   out_symbol;
  logic         last_of_run;
  logic         expression_done;
  itp_pkg::err_e error_code;

  modport source (output valid, output out_symbol, output last_of_run,
                  output expression_done, output error_code, input ready);
  modport sink   (input valid, input out_symbol, input last_of_run,
                  input expression_done, input error_code, output ready);
endinterface

FILE: rtl/itp_ctrl.sv
module itp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  itp_pkg::stat_t stat_i,
  output itp_pkg::cmd_t  cmd_o
);
  import itp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GAP
  } state_e;

  state_e state_q, state_d;
  logic   open_seen_q, open_seen_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    open_seen_d = open_seen_q;
    cmd_o       = '0;
    cmd_o.sel   = SEL_ZERO;
    cmd_o.err   = ERR_OK;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          open_seen_d = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.out_free) begin
          if (stat_i.eoe) begin
            if (!stat_i.empty && stat_i.top_open) begin
              // drop the stray open, remember it for the terminator
              cmd_o.pop   = 1'b1;
              open_seen_d = 1'b1;
            end else if (!stat_i.empty) begin
              cmd_o.emit = 1'b1;
              cmd_o.sel  = SEL_TOP;
              cmd_o.pop  = 1'b1;
              state_d    = ST_GAP;
            end else begin
              cmd_o.emit = 1'b1;
              cmd_o.sel  = SEL_ZERO;
              cmd_o.last = 1'b1;
              cmd_o.done = 1'b1;
              cmd_o.err  = open_seen_q ? ERR_OPEN : ERR_OK;
              state_d    = ST_IDLE;
            end
          end else if (stat_i.is_close) begin
            if (stat_i.empty) begin
              cmd_o.emit = 1'b1;
              cmd_o.sel  = SEL_ZERO;
              cmd_o.last = 1'b1;
              cmd_o.err  = ERR_CLOSE;
              state_d    = ST_IDLE;
            end else if (stat_i.top_open) begin
              cmd_o.pop = 1'b1;
              state_d   = ST_IDLE;
            end else begin
              cmd_o.emit = 1'b1;
              cmd_o.sel  = SEL_TOP;
              cmd_o.pop  = 1'b1;
              state_d    = ST_GAP;
            end
          end else begin
            case (stat_i.cls)
              OP_NONE: begin
                cmd_o.emit = 1'b1;
                cmd_o.sel  = SEL_SYM;
                cmd_o.last = 1'b1;
                state_d    = ST_IDLE;
              end
              OP_OPEN: begin
                if (stat_i.full) begin
                  cmd_o.emit = 1'b1;
                  cmd_o.sel  = SEL_ZERO;
                  cmd_o.last = 1'b1;
                  cmd_o.err  = ERR_FULL;
                end else begin
                  cmd_o.push = 1'b1;
                end
                state_d = ST_IDLE;
              end
              default: begin
                if (!stat_i.empty && !stat_i.top_open && stat_i.top_ge) begin
                  cmd_o.emit = 1'b1;
                  cmd_o.sel  = SEL_TOP;
                  cmd_o.pop  = 1'b1;
                  state_d    = ST_GAP;
                end else begin
                  cmd_o.emit = 1'b1;
                  cmd_o.sel  = SEL_SPACE;
                  cmd_o.last = 1'b1;
                  cmd_o.err  = stat_i.full ? ERR_FULL : ERR_OK;
                  cmd_o.push = !stat_i.full;
                  state_d    = ST_IDLE;
                end
              end
            endcase
          end
        end
      end
      ST_GAP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_SPACE;
          state_d    = ST_SCAN;
          // a close run may end here: on an empty stack or at its open
          if (!stat_i.eoe && stat_i.is_close) begin
            if (stat_i.empty) begin
              cmd_o.last = 1'b1;
              cmd_o.err  = ERR_CLOSE;
              state_d    = ST_IDLE;
            end else if (stat_i.top_open) begin
              cmd_o.last = 1'b1;
              cmd_o.pop  = 1'b1;
              state_d    = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      open_seen_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_seen_q <= open_seen_d;
    end
  end

endmodule

FILE: rtl/itp_dp.sv
module itp_dp #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     symbol_i,
  input  logic           eoe_i,
  input  itp_pkg::cmd_t  cmd_i,
  output itp_pkg::stat_t stat_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [7:0]     out_symbol_o,
  output logic           last_o,
  output logic           done_o,
  output itp_pkg::err_e  err_o
);
  import itp_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);

  op_code_e       stack_q [STACK_DEPTH];
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [7:0] sym_q;
  logic       eoe_q;
  op_code_e   cls_q;

  op_code_e   top;
  logic [7:0] char_d;
  logic       out_valid_q;
  logic [7:0] out_sym_q;
  logic       last_q, done_q;
  err_e       err_q;

  assign top = stack_q[IdxW'(cnt_q - CntW'(1))];

  assign stat_o.eoe      = eoe_q;
  assign stat_o.is_close = (sym_q == CH_CLOSE);
  assign stat_o.cls      = cls_q;
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.full     = (cnt_q == CntW'(STACK_DEPTH));
  assign stat_o.top_open = (top == OP_OPEN);
  assign stat_o.top_ge   = (code_prec(top) >= code_prec(cls_q));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.push) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_SYM:   char_d = sym_q;
      SEL_TOP:   char_d = code_char(top);
      SEL_SPACE: char_d = CH_SPACE;
      default:   char_d = CH_NUL;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_q[IdxW'(cnt_q)] <= cls_q;
    end
    if (cmd_i.load) begin
      sym_q <= symbol_i;
      eoe_q <= eoe_i;
      cls_q <= classify(symbol_i);
    end
    if (cmd_i.emit) begin
      out_sym_q <= char_d;
      last_q    <= cmd_i.last;
      done_q    <= cmd_i.done;
      err_q     <= cmd_i.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign last_o       = last_q;
  assign done_o       = done_q;
  assign err_o        = err_q;

endmodule

FILE: rtl/infix_to_postfix_converter_unit.sv
// Infix to postfix converter, shunting-yard style, one character per input word.
// Input channel in_i: symbol plus end_of_expression; an end word flushes the
// operator stack and closes the expression with a NUL terminator word.
// Output channel out_o: one postfix character per word, with last_of_run on the
// final word an input causes, expression_done on the terminator and error_code
// (stack full, unmatched close, unmatched open) on that final word only.
// Timing: a word is taken in the idle state, then the controller takes one action
// per cycle while the output register is free. An operand, an operator's space or
// an error-only word is written from the scan state into the output register. Each
// popped operator adds two words (its character and its space), each open
// parenthesis dropped by a flush an action with no word; a close that pops
// operators ends on its last space. All actions go through the single output
// register. Words that produce no output still pass through the scan state.
// Stall: while out_o.ready is low and the output register is full, the controller
// holds its next action; the next input word is taken as soon as the current one
// has issued its last output word, even while that word waits in the register.
// Reset: rst_ni clears the stack count, the controller and the output valid;
// stack entries are not cleared and are only read below the count.
`include "infix_to_postfix_converter_unit_macros.svh"

module infix_to_postfix_converter_unit #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itp_in_if.sink     in_i,
  itp_out_if.source  out_o
);
  import itp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: decide one stack action per cycle while the output register is free.
  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Stack, current word and output register.
  itp_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .symbol_i     (in_i.symbol),
    .eoe_i        (in_i.end_of_expression),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_symbol_o (out_o.out_symbol),
    .last_o       (out_o.last_of_run),
    .done_o       (out_o.expression_done),
    .err_o        (out_o.error_code)
  );

  // The terminator always closes the run.
  `ITP_ASSERT_IMP(a_done_is_last, out_o.valid && out_o.expression_done, out_o.last_of_run, "terminator without last_of_run")
  // Errors ride only on the final word of a run.
  `ITP_ASSERT_IMP(a_err_on_last, out_o.valid && (out_o.error_code != ERR_OK), out_o.last_of_run, "error code on a non-final word")
  // An unmatched open is reported only by the terminator.
  `ITP_ASSERT_IMP(a_open_on_done, out_o.valid && (out_o.error_code == ERR_OPEN), out_o.expression_done, "unmatched open off the terminator")
  // After taking a word the block is busy in the following cycle.
  `ITP_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "input taken back to back")

endmodule

FILE: verif/infix_to_postfix_converter_unit_test.sv
module infix_to_postfix_converter_unit_test;
  import itp_pkg::*;

  localparam int unsigned STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_WORDS = 430;
  // A full flush is two output words per stacked operator.
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int HOLD_OFF_AFTER = 200;
  localparam int MAX_REPORTS = 50;

  typedef struct {
    logic [7:0] symbol;
    logic       eoe;
    bit         drain;
  } infix_word_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       done;
    err_e       err;
  } postfix_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Drive the interface inputs from initialized variables so that they are
  // known from the first time step.
  logic       in_valid = 1'b0;
  logic [7:0] in_symbol = CH_NUL;
  logic       in_eoe = 1'b0;
  logic       out_ready = 1'b0;

  itp_in_if  in_bus ();
  itp_out_if out_bus ();

  assign in_bus.valid             = in_valid;
  assign in_bus.symbol            = in_symbol;
  assign in_bus.end_of_expression = in_eoe;
  assign out_bus.ready            = out_ready;

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Infix words still to be sent, and postfix words the block still owes.
  infix_word_t   infix_words[$];
  postfix_word_t postfix_expected[$];
  postfix_word_t run_words[$];

  // Shadow copy of the operator stack.
  op_code_e op_stack[STACK_DEPTH];
  int       op_depth = 0;

  int  total_words = 0;
  int  words_taken = 0;
  int  words_seen = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  drain_next = 1'b0;
  logic quiet = 1'b0;
  logic long_hold = 1'b0;
  logic next_valid;
  infix_word_t next_word;

  // ---------------------------------------------------------------------
  // Operator helpers for the shadow stack
  // ---------------------------------------------------------------------
  function automatic op_code_e op_of_char(input logic [7:0] ch);
    case (ch)
      CH_OPEN: return OP_OPEN;
      CH_ADD:  return OP_ADD;
      CH_SUB:  return OP_SUB;
      CH_MUL:  return OP_MUL;
      CH_DIV:  return OP_DIV;
      CH_POW:  return OP_POW;
      default: return OP_NONE;
    endcase
  endfunction

  function automatic logic [7:0] char_of_op(input op_code_e op);
    case (op)
      OP_ADD:  return CH_ADD;
      OP_SUB:  return CH_SUB;
      OP_MUL:  return CH_MUL;
      OP_DIV:  return CH_DIV;
      OP_POW:  return CH_POW;
      OP_OPEN: return CH_OPEN;
      default: return CH_NUL;
    endcase
  endfunction

  // Binding strength; an open parenthesis never pops anything.
  function automatic int rank_of_op(input op_code_e op);
    case (op)
      OP_POW:         return 3;
      OP_MUL, OP_DIV: return 2;
      OP_ADD, OP_SUB: return 1;
      default:        return 0;
    endcase
  endfunction

  function automatic void emit_char(input logic [7:0] ch, input logic done);
    postfix_word_t w;
    w.symbol = ch;
    w.last   = 1'b0;
    w.done   = done;
    w.err    = ERR_OK;
    run_words.push_back(w);
  endfunction

  // Pop the top operator: its character, then a space.
  function automatic void pop_operator();
    op_depth = op_depth - 1;
    emit_char(char_of_op(op_stack[op_depth]), 1'b0);
    emit_char(CH_SPACE, 1'b0);
  endfunction

  function automatic bit push_operator(input op_code_e op);
    if (op_depth >= STACK_DEPTH) return 1'b0;
    op_stack[op_depth] = op;
    op_depth = op_depth + 1;
    return 1'b1;
  endfunction

  // Work out every postfix word that one accepted infix word causes and
  // queue them in order; the last one carries last_of_run and the error.
  function automatic void predict_postfix(input logic [7:0] sym, input logic eoe);
    op_code_e      code;
    err_e          err;
    bit            matched;
    postfix_word_t w;
    run_words.delete();
    err = ERR_OK;
    if (eoe) begin
      // Flush: emit operators, drop stray open parentheses, then terminate.
      while (op_depth > 0) begin
        if (op_stack[op_depth - 1] == OP_OPEN) begin
          op_depth = op_depth - 1;
          err = ERR_OPEN;
        end else begin
          pop_operator();
        end
      end
      emit_char(CH_NUL, 1'b1);
    end else if (sym == CH_CLOSE) begin
      matched = 1'b0;
      while (op_depth > 0 && !matched) begin
        if (op_stack[op_depth - 1] == OP_OPEN) begin
          op_depth = op_depth - 1;
          matched = 1'b1;
        end else begin
          pop_operator();
        end
      end
      if (!matched) err = ERR_CLOSE;
    end else begin
      code = op_of_char(sym);
      if (code == OP_NONE) begin
        emit_char(sym, 1'b0);
      end else if (code == OP_OPEN) begin
        if (!push_operator(code)) err = ERR_FULL;
      end else begin
        while (op_depth > 0 && op_stack[op_depth - 1] != OP_OPEN &&
               rank_of_op(op_stack[op_depth - 1]) >= rank_of_op(code)) begin
          pop_operator();
        end
        emit_char(CH_SPACE, 1'b0);
        if (!push_operator(code)) err = ERR_FULL;
      end
    end
    // An error with nothing else to say still gets a word of its own.
    if (err != ERR_OK && run_words.size() == 0) emit_char(CH_NUL, 1'b0);
    if (run_words.size() > 0) begin
      w = run_words[$];
      w.last = 1'b1;
      w.err = err;
      run_words[$] = w;
    end
    foreach (run_words[i]) postfix_expected.push_back(run_words[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("ERROR output word %0d: %s got 0x%0h expected 0x%0h",
               words_seen, what, got, want);
    end
    mismatch_count = mismatch_count + 1;
  endtask

  task automatic check_postfix(input logic [7:0] sym, input logic last, input logic done,
                               input err_e err);
    postfix_word_t want;
    if (postfix_expected.size() == 0) begin
      report_mismatch("unexpected word, symbol", sym, 0);
    end else begin
      want = postfix_expected.pop_front();
      if (sym !== want.symbol) report_mismatch("out_symbol", sym, want.symbol);
      if (last !== want.last) report_mismatch("last_of_run", last, want.last);
      if (done !== want.done) report_mismatch("expression_done", done, want.done);
      if (err !== want.err) report_mismatch("error_code", err, want.err);
    end
    words_seen = words_seen + 1;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_word(input logic [7:0] sym, input logic eoe);
    infix_word_t w;
    w.symbol = sym;
    w.eoe = eoe;
    w.drain = drain_next;
    drain_next = 1'b0;
    infix_words.push_back(w);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_word(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 4))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // Letters and digits mostly, now and then any byte that is not an operator.
  function automatic logic [7:0] rand_operand();
    logic [7:0] ch;
    case ($urandom_range(0, 7))
      0: begin
        ch = 8'($urandom_range(0, 255));
        if (op_of_char(ch) != OP_NONE || ch == CH_CLOSE) ch = 8'h78;
      end
      1, 2:    ch = 8'($urandom_range(48, 57));
      default: ch = 8'($urandom_range(97, 122));
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] rand_noise_char();
    case ($urandom_range(0, 3))
      0:       return rand_operator();
      1:       return $urandom_range(0, 1) ? CH_OPEN : CH_CLOSE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Well-formed infix expression with random operands, operators and nesting.
  task automatic gen_expression();
    int depth;
    int operands;
    int wanted;
    bit need_operand;
    bit finished;
    depth = 0;
    operands = 0;
    wanted = $urandom_range(1, 6);
    need_operand = 1'b1;
    finished = 1'b0;
    while (!finished) begin
      if (need_operand) begin
        if (depth < 6 && $urandom_range(0, 3) == 0) begin
          add_word(CH_OPEN, 1'b0);
          depth = depth + 1;
        end else begin
          add_word(rand_operand(), 1'b0);
          operands = operands + 1;
          need_operand = 1'b0;
        end
      end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
        add_word(CH_CLOSE, 1'b0);
        depth = depth - 1;
      end else if (operands >= wanted) begin
        finished = 1'b1;
      end else begin
        add_word(rand_operator(), 1'b0);
        need_operand = 1'b1;
      end
    end
    repeat (depth) add_word(CH_CLOSE, 1'b0);
    add_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Deep nesting, in one branch enough to overflow the stack, closed partly or not at all.
  task automatic gen_deep_nest();
    int levels;
    levels = $urandom_range(6, 12);
    if ($urandom_range(0, 2) == 0) begin
      repeat (STACK_DEPTH + 1 + $urandom_range(0, 2)) add_word(CH_OPEN, 1'b0);
      add_word(rand_operand(), 1'b0);
    end else begin
      repeat (levels) begin
        add_word(CH_OPEN, 1'b0);
        add_word(rand_operand(), 1'b0);
        add_word(rand_operator(), 1'b0);
      end
      add_word(rand_operand(), 1'b0);
    end
    if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, levels)) add_word(CH_CLOSE, 1'b0);
    add_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Broken input: any byte, stray parentheses, early end words.
  task automatic gen_noise();
    repeat ($urandom_range(3, 10)) begin
      if ($urandom_range(0, 7) == 0) add_word(8'($urandom_range(0, 255)), 1'b1);
      else add_word(rand_noise_char(), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: present one infix word at a time from the pending queue.
  // A word with its drain flag set waits until every owed output word has
  // arrived, so the block starts it from an empty pipeline.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_symbol <= CH_NUL;
      in_eoe <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_bus.ready) begin
        predict_postfix(in_symbol, in_eoe);
        words_taken = words_taken + 1;
      end
      // Advance only once the current word is gone; hold it otherwise.
      if (!in_valid || in_bus.ready) begin
        next_valid = 1'b0;
        if (gap_left > 0 && !quiet) begin
          gap_left = gap_left - 1;
        end else if (infix_words.size() != 0 &&
                     !(infix_words[0].drain && postfix_expected.size() != 0)) begin
          next_word = infix_words.pop_front();
          in_symbol <= next_word.symbol;
          in_eoe <= next_word.eoe;
          next_valid = 1'b1;
          gap_left = pick_gap();
        end
        in_valid <= next_valid;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check each accepted output word, and stall the output at
  // random. The long hold-off comes from its own process below.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_bus.valid && out_ready) begin
        check_postfix(out_bus.out_symbol, out_bus.last_of_run, out_bus.expression_done,
                      out_bus.error_code);
      end
      if (stall_left > 0 && !quiet) begin
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        if (!quiet && $urandom_range(0, 4) == 0) stall_left = 1 + pick_gap();
        out_ready <= !long_hold;
      end
    end
  end

  // Hold off the output for a long stretch mid-run while the driver keeps
  // offering words, so the block backs up and stalls its input.
  initial begin
    wait (words_taken >= HOLD_OFF_AFTER);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Cycle count, quiet stretches without any idling, and the run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    quiet <= ((cycle_count / 700) % 5) == 4;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus list and end of run
  // ---------------------------------------------------------------------
  initial begin
    int directed_words;
    int pick;

    // Operand extremes, then an end word whose symbol must be ignored.
    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(CH_CLOSE, 1'b1);
    // Close on an empty stack: error-only word.
    add_word(CH_CLOSE, 1'b0);
    // Every operator and every precedence step.
    add_text("a+b*c^d-e/f");
    add_word(CH_NUL, 1'b1);
    // Open parenthesis left over at the flush.
    add_text("(a");
    add_word(8'hA5, 1'b1);
    // Matched parentheses.
    add_text("(a-b)");
    add_word(CH_NUL, 1'b1);
    directed_words = infix_words.size();

    // Random part: mostly well-formed expressions, some overflowing nests,
    // some noise. Now and then start a sequence from a drained block.
    drain_next = 1'b1;
    while (infix_words.size() < directed_words + RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) drain_next = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 13) gen_expression();
      else if (pick < 15) gen_deep_nest();
      else gen_noise();
    end
    total_words = infix_words.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken < total_words) @(posedge clk_i);
    while (postfix_expected.size() != 0) @(posedge clk_i);
    // Let any stray output word show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
